// ===== hdl/bilr_pkg.sv =====
package bilr_pkg;

   localparam int PIX_W      = 8;
   localparam int OFF_W      = 36;
   localparam int SIZE_W     = 13;
   localparam int ORDER_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;
   localparam int QUEUE_DEPTH = 4;

   // stored organization codes; anything else is handled as pixel interleaved
   localparam logic [ORDER_W-1:0] ORDER_BSQ = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_BIL = 2'd1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_ORDER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM0_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM1_SIZE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM2_SIZE  = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd1;

   typedef struct packed {
      logic [ORDER_W-1:0] data_order;
      logic [SIZE_W-1:0]  dim0_size;
      logic [SIZE_W-1:0]  dim1_size;
      logic [SIZE_W-1:0]  dim2_size;
   } bilr_cfg_type;

   typedef struct packed {
      logic empty;
      logic full;
   } bilr_q_status_type;

endpackage

// ===== hdl/bilr_front.sv =====
module bilr_front #(
   parameter int MAX_DIM = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bilr_pkg::bilr_cfg_type            cfg,
   input  logic                              accept,
   output logic [$clog2(MAX_DIM)-1:0]        col,
   output logic [$clog2(MAX_DIM)-1:0]        line,
   output logic [$clog2(MAX_DIM)-1:0]        band,
   output logic                              done,
   output logic [$clog2(MAX_DIM+1)-1:0]      ncols,
   output logic [$clog2(MAX_DIM+1)-1:0]      nbands
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int SZ_W  = $clog2(MAX_DIM + 1);

   logic [CNT_W-1:0] fast_ff, fast_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] slow_ff, slow_in;
   logic [SZ_W-1:0]  s0, s1, s2;
   logic             last0, last1, last2;

   // zero acts as one, anything above the maximum is clamped
   function automatic logic [SZ_W-1:0] eff_size(input logic [bilr_pkg::SIZE_W-1:0] reg_val);
      logic [31:0] wide;
      wide = 32'(reg_val);
      if (wide == 32'd0) begin
         eff_size = SZ_W'(1);
      end else if (wide > 32'(MAX_DIM)) begin
         eff_size = SZ_W'(MAX_DIM);
      end else begin
         eff_size = SZ_W'(wide);
      end
   endfunction

   assign s0 = eff_size(cfg.dim0_size);
   assign s1 = eff_size(cfg.dim1_size);
   assign s2 = eff_size(cfg.dim2_size);

   // a counter at or past its size counts as the last position
   assign last0 = (SZ_W'(fast_ff) + SZ_W'(1)) >= s0;
   assign last1 = (SZ_W'(mid_ff) + SZ_W'(1)) >= s1;
   assign last2 = (SZ_W'(slow_ff) + SZ_W'(1)) >= s2;
   assign done  = last0 && last1 && last2;

   always_comb begin
      fast_in = fast_ff;
      mid_in  = mid_ff;
      slow_in = slow_ff;
      if (accept) begin
         if (!last0) begin
            fast_in = fast_ff + CNT_W'(1);
         end else begin
            fast_in = '0;
            if (!last1) begin
               mid_in = mid_ff + CNT_W'(1);
            end else begin
               mid_in  = '0;
               slow_in = last2 ? '0 : slow_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff <= '0;
         mid_ff  <= '0;
         slow_ff <= '0;
      end else begin
         fast_ff <= fast_in;
         mid_ff  <= mid_in;
         slow_ff <= slow_in;
      end
   end

   // map stored dimensions to column, line and band
   always_comb begin
      case (cfg.data_order)
         bilr_pkg::ORDER_BSQ: begin
            col    = fast_ff;
            line   = mid_ff;
            band   = slow_ff;
            ncols  = s0;
            nbands = s2;
         end
         bilr_pkg::ORDER_BIL: begin
            col    = fast_ff;
            band   = mid_ff;
            line   = slow_ff;
            ncols  = s0;
            nbands = s1;
         end
         default: begin
            band   = fast_ff;
            col    = mid_ff;
            line   = slow_ff;
            nbands = s0;
            ncols  = s1;
         end
      endcase
   end

endmodule

// ===== hdl/bilr_queue.sv =====
module bilr_queue #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            pop_data,
   output bilr_pkg::bilr_q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/bilr_back.sv =====
module bilr_back #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bilr_pkg::bilr_q_status_type          q_status,
   input  logic [bilr_pkg::PIX_W-1:0]           q_pixel,
   input  logic [$clog2(MAX_DIM)-1:0]           q_col,
   input  logic [$clog2(MAX_DIM)-1:0]           q_line,
   input  logic [$clog2(MAX_DIM)-1:0]           q_band,
   input  logic                                 q_done,
   input  logic [$clog2(MAX_DIM+1)-1:0]         ncols,
   input  logic [$clog2(MAX_DIM+1)-1:0]         nbands,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bilr_pkg::OFF_W-1:0]           rsp_dest_offset,
   output logic [bilr_pkg::PIX_W-1:0]           rsp_pixel_out,
   output logic                                 rsp_cube_done
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int SZ_W  = $clog2(MAX_DIM + 1);
   localparam int PL_W  = 2 * SZ_W;
   localparam int LP_W  = CNT_W + PL_W;
   localparam int CP_W  = CNT_W + SZ_W;
   localparam int SUM_W = LP_W + 1;

   logic [PL_W-1:0]            plane_ff, plane_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic [LP_W-1:0]            s1_line_prod_ff, s1_line_prod_in;
   logic [CP_W-1:0]            s1_col_prod_ff, s1_col_prod_in;
   logic [CNT_W-1:0]           s1_band_ff;
   logic [bilr_pkg::PIX_W-1:0] s1_pixel_ff;
   logic                       s1_done_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [bilr_pkg::OFF_W-1:0] out_offset_ff, out_offset_in;
   logic [bilr_pkg::PIX_W-1:0] out_pixel_ff;
   logic                       out_done_ff;
   logic                       out_load;
   logic [SUM_W-1:0]           sum;

   // user changes sizes only while idle (unenforced); plane size is ready for each pixel
   assign plane_in = PL_W'(ncols) * PL_W'(nbands);

   assign out_load = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign q_pop    = !q_status.empty && (!s1_valid_ff || out_load);

   assign s1_line_prod_in = LP_W'(q_line) * LP_W'(plane_ff);
   assign s1_col_prod_in  = CP_W'(q_col) * CP_W'(nbands);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
   end

   assign sum = SUM_W'(s1_line_prod_ff) + SUM_W'(s1_col_prod_ff) + SUM_W'(s1_band_ff);
   assign out_offset_in = bilr_pkg::OFF_W'(sum);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
      if (q_pop) begin
         s1_line_prod_ff <= s1_line_prod_in;
         s1_col_prod_ff  <= s1_col_prod_in;
         s1_band_ff      <= q_band;
         s1_pixel_ff     <= q_pixel;
         s1_done_ff      <= q_done;
      end
      // hold the result while the consumer stalls
      if (out_load) begin
         out_offset_ff <= out_offset_in;
         out_pixel_ff  <= s1_pixel_ff;
         out_done_ff   <= s1_done_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_dest_offset = out_offset_ff;
   assign rsp_pixel_out   = out_pixel_ff;
   assign rsp_cube_done   = out_done_ff;

endmodule

// ===== hdl/band_interleave_to_bip_reorder.sv =====
// Channel   Ports                                                   Direction
// req       req_valid, req_stall, req_pixel_in                      in
// rsp       rsp_valid, rsp_stall, rsp_dest_offset, rsp_pixel_out,   out
//           rsp_cube_done
// csr       csr_we, csr_index, csr_wdata                            in (write only)
//
// One pixel per clock sustained while rsp is not stalled; a transaction on req
// passes through the queue, the multiply stage and the sum into the output
// register, from which rsp_valid rises.
// The address multiplies (line by plane size, column by band count) sit in
// one pipeline stage behind a four-entry queue.
// Synchronous reset clears the counters, the queue, the pipeline and the
// registers to band sequential with all sizes one; there is no clearing pass.
// A stall on rsp fills the queue; req_stall rises only when the queue is full.
module band_interleave_to_bip_reorder #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bilr_pkg::PIX_W-1:0]          req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bilr_pkg::OFF_W-1:0]          rsp_dest_offset,
   output logic [bilr_pkg::PIX_W-1:0]          rsp_pixel_out,
   output logic                                rsp_cube_done,
   input  logic                                csr_we,
   input  logic [bilr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bilr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int SZ_W  = $clog2(MAX_DIM + 1);
   localparam int ENT_W = bilr_pkg::PIX_W + 3 * CNT_W + 1;

   bilr_pkg::bilr_cfg_type      cfg_ff, cfg_in;
   bilr_pkg::bilr_q_status_type q_status;
   logic                        req_accept;
   logic [CNT_W-1:0]            f_col, f_line, f_band;
   logic                        f_done;
   logic [SZ_W-1:0]             ncols, nbands;
   logic [ENT_W-1:0]            q_wr_data, q_rd_data;
   logic                        q_pop;
   logic [bilr_pkg::PIX_W-1:0]  q_pixel;
   logic [CNT_W-1:0]            q_col, q_line, q_band;
   logic                        q_done;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bilr_pkg::CSR_DATA_ORDER: cfg_in.data_order = csr_wdata[bilr_pkg::ORDER_W-1:0];
            bilr_pkg::CSR_DIM0_SIZE:  cfg_in.dim0_size  = csr_wdata;
            bilr_pkg::CSR_DIM1_SIZE:  cfg_in.dim1_size  = csr_wdata;
            bilr_pkg::CSR_DIM2_SIZE:  cfg_in.dim2_size  = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_order <= bilr_pkg::ORDER_BSQ;
         cfg_ff.dim0_size  <= bilr_pkg::SIZE_RESET;
         cfg_ff.dim1_size  <= bilr_pkg::SIZE_RESET;
         cfg_ff.dim2_size  <= bilr_pkg::SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   bilr_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (req_accept),
      .col    (f_col),
      .line   (f_line),
      .band   (f_band),
      .done   (f_done),
      .ncols  (ncols),
      .nbands (nbands)
   );

   assign q_wr_data = {req_pixel_in, f_col, f_line, f_band, f_done};

   bilr_queue #(
      .DEPTH (bilr_pkg::QUEUE_DEPTH),
      .WIDTH (ENT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (q_wr_data),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .status    (q_status)
   );

   assign {q_pixel, q_col, q_line, q_band, q_done} = q_rd_data;

   bilr_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_pixel         (q_pixel),
      .q_col           (q_col),
      .q_line          (q_line),
      .q_band          (q_band),
      .q_done          (q_done),
      .ncols           (ncols),
      .nbands          (nbands),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dest_offset (rsp_dest_offset),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_cube_done   (rsp_cube_done)
   );

endmodule

// ===== hdl/bilr_check.sv =====
module bilr_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bilr_pkg::OFF_W-1:0]      rsp_dest_offset,
   input logic [bilr_pkg::PIX_W-1:0]      rsp_pixel_out,
   input logic                            rsp_cube_done
);

   logic [3:0] pending_ff, pending_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // transactions taken on req whose result has not yet been taken on rsp
   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 4'd1;
      end else if (rsp_acc && !req_acc) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dest_offset)
         && $stable(rsp_pixel_out) && $stable(rsp_cube_done))
      else $error("rsp transaction changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("rsp valid without a pending req transaction");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("req stalled right after reset");

endmodule

bind band_interleave_to_bip_reorder bilr_check u_bilr_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_dest_offset (rsp_dest_offset),
   .rsp_pixel_out   (rsp_pixel_out),
   .rsp_cube_done   (rsp_cube_done)
);

// ===== verif/band_interleave_to_bip_reorder_tb.sv =====
`timescale 1ns / 1ps

module band_interleave_to_bip_reorder_tb;

   localparam int MAX_DIM      = 4096;
   localparam int COUNT_W      = $clog2(MAX_DIM);
   localparam int RANDOM_ITEMS = 1450;
   localparam int STUCK_LIMIT  = 1000;
   localparam int PRINT_CAP    = 200;

   localparam int PIX_W      = bilr_pkg::PIX_W;
   localparam int OFF_W      = bilr_pkg::OFF_W;
   localparam int SIZE_W     = bilr_pkg::SIZE_W;
   localparam int ORDER_W    = bilr_pkg::ORDER_W;
   localparam int CSR_IDX_W  = bilr_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = bilr_pkg::CSR_DATA_W;

   // organization codes the package leaves unnamed
   localparam logic [ORDER_W-1:0] ORDER_BIP   = 2'd2;
   localparam logic [ORDER_W-1:0] ORDER_SPARE = 2'd3;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic [PIX_W-1:0] pixel;
      logic             done;
   } bip_slot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [OFF_W-1:0]      rsp_dest_offset;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_cube_done;
   logic                  csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   // predictor copy of the registers and the stored-order position
   logic [ORDER_W-1:0] order_reg = bilr_pkg::ORDER_BSQ;
   logic [SIZE_W-1:0]  size0_reg = bilr_pkg::SIZE_RESET;
   logic [SIZE_W-1:0]  size1_reg = bilr_pkg::SIZE_RESET;
   logic [SIZE_W-1:0]  size2_reg = bilr_pkg::SIZE_RESET;
   logic [COUNT_W-1:0] pos0 = '0;
   logic [COUNT_W-1:0] pos1 = '0;
   logic [COUNT_W-1:0] pos2 = '0;

   logic [PIX_W-1:0] pixel_queue[$];
   bip_slot_type     slot_queue[$];

   int mismatches   = 0;
   int sent_total   = 0;
   int results_seen = 0;
   int stuck_cycles = 0;
   int gap_left     = 0;
   int stall_left   = 0;
   bit req_taken    = 1'b0;
   bit calm         = 1'b0;

   band_interleave_to_bip_reorder #(
      .MAX_DIM(MAX_DIM)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_dest_offset(rsp_dest_offset),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_cube_done(rsp_cube_done),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      if (mismatches < PRINT_CAP) begin
         $display("ERROR %0t: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [OFF_W-1:0] got,
                              input logic [OFF_W-1:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      if (raw == '0) begin
         return SIZE_W'(1);
      end
      if (raw > MAX_DIM) begin
         return SIZE_W'(MAX_DIM);
      end
      return raw;
   endfunction

   // destination offset of the current stored position, then advance it
   task automatic place_pixel(input logic [PIX_W-1:0] pixel, output bip_slot_type slot);
      logic [SIZE_W-1:0] s0, s1, s2;
      logic [OFF_W-1:0]  col, row, band, ncols, nbands;
      logic              last0, last1, last2;
      s0 = eff_size(size0_reg);
      s1 = eff_size(size1_reg);
      s2 = eff_size(size2_reg);
      case (order_reg)
         bilr_pkg::ORDER_BSQ: begin
            col = OFF_W'(pos0); row = OFF_W'(pos1); band = OFF_W'(pos2);
            ncols = OFF_W'(s0); nbands = OFF_W'(s2);
         end
         bilr_pkg::ORDER_BIL: begin
            col = OFF_W'(pos0); band = OFF_W'(pos1); row = OFF_W'(pos2);
            ncols = OFF_W'(s0); nbands = OFF_W'(s1);
         end
         default: begin
            band = OFF_W'(pos0); col = OFF_W'(pos1); row = OFF_W'(pos2);
            nbands = OFF_W'(s0); ncols = OFF_W'(s1);
         end
      endcase
      // a position at or past a shrunken size counts as the last one
      last0 = (int'(pos0) + 1) >= int'(s0);
      last1 = (int'(pos1) + 1) >= int'(s1);
      last2 = (int'(pos2) + 1) >= int'(s2);
      slot.offset = row * (ncols * nbands) + col * nbands + band;
      slot.pixel  = pixel;
      slot.done   = last0 && last1 && last2;
      if (!last0) begin
         pos0 = pos0 + COUNT_W'(1);
      end else begin
         pos0 = '0;
         if (!last1) begin
            pos1 = pos1 + COUNT_W'(1);
         end else begin
            pos1 = '0;
            if (!last2) begin
               pos2 = pos2 + COUNT_W'(1);
            end else begin
               pos2 = '0;
            end
         end
      end
   endtask

   // sender: one transaction per free cycle, random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled transaction
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (pixel_queue.size() != 0) begin
         req_valid    <= 1'b1;
         req_pixel_in <= pixel_queue.pop_front();
         if (!calm && $urandom_range(0, 6) == 0) begin
            gap_left <= $urandom_range(1, 8);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver back-pressure in bursts
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(1, 8);
         end
      end
   end

   always @(posedge clock) begin : monitor
      bip_slot_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            place_pixel(req_pixel_in, want);
            slot_queue.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (slot_queue.size() == 0) begin
               report_error("result transaction with nothing expected");
            end else begin
               want = slot_queue.pop_front();
               check_field("dest_offset", rsp_dest_offset, want.offset);
               check_field("pixel_out", OFF_W'(rsp_pixel_out), OFF_W'(want.pixel));
               check_field("cube_done", OFF_W'(rsp_cube_done), OFF_W'(want.done));
               results_seen <= results_seen + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         bilr_pkg::CSR_DATA_ORDER: order_reg = value[ORDER_W-1:0];
         bilr_pkg::CSR_DIM0_SIZE:  size0_reg = value;
         bilr_pkg::CSR_DIM1_SIZE:  size1_reg = value;
         bilr_pkg::CSR_DIM2_SIZE:  size2_reg = value;
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] order_word,
                             input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                             input logic [SIZE_W-1:0] s2);
      write_reg(bilr_pkg::CSR_DATA_ORDER, order_word);
      write_reg(bilr_pkg::CSR_DIM0_SIZE, s0);
      write_reg(bilr_pkg::CSR_DIM1_SIZE, s1);
      write_reg(bilr_pkg::CSR_DIM2_SIZE, s2);
   endtask

   // wait until every pixel is out and every result is back
   task automatic settle();
      do @(posedge clock);
      while (pixel_queue.size() != 0 || req_valid || results_seen != sent_total);
   endtask

   task automatic run_pixels(input int count);
      @(posedge clock);
      repeat (count) pixel_queue.push_back(PIX_W'($urandom_range(0, 255)));
      sent_total += count;
      settle();
   endtask

   // mostly tiny cubes so they complete, with degenerate and oversized sizes
   function automatic logic [SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return '0;
      if (r < 10) return SIZE_W'($urandom_range(MAX_DIM + 1, 8191));
      if (r < 13) return SIZE_W'(MAX_DIM);
      if (r < 20) return SIZE_W'($urandom_range(7, 40));
      return SIZE_W'($urandom_range(1, 6));
   endfunction

   initial begin
      int phase;
      int random_start;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset sizes: every pixel is a whole cube at offset zero
      @(posedge clock);
      pixel_queue.push_back(8'h00);
      pixel_queue.push_back(8'hFF);
      sent_total += 2;
      settle();

      // each organization once, unused high bits of the order word set on the first
      set_config({11'h7FF, bilr_pkg::ORDER_BSQ}, 13'd2, 13'd1, 13'd2);
      run_pixels(4);
      set_config({11'h000, bilr_pkg::ORDER_BIL}, 13'd2, 13'd2, 13'd1);
      run_pixels(4);
      set_config({11'h000, ORDER_BIP}, 13'd2, 13'd1, 13'd2);
      run_pixels(4);
      set_config({11'h000, ORDER_SPARE}, 13'd2, 13'd1, 13'd2);
      run_pixels(4);

      // zero size acts as one, oversized acts as the maximum; stop mid-cube
      set_config({11'h000, bilr_pkg::ORDER_BSQ}, 13'd0, 13'h1FFF, 13'd1);
      run_pixels(3);
      // shrink the middle dimension below the counter
      write_reg(bilr_pkg::CSR_DIM1_SIZE, 13'd2);
      run_pixels(2);

      random_start = sent_total;
      phase = 0;
      while (sent_total - random_start < RANDOM_ITEMS) begin
         if (sent_total - random_start > RANDOM_ITEMS - 150) begin
            calm = 1'b1;
         end else begin
            calm = ($urandom_range(0, 5) == 0);
         end
         if (phase == 4) begin
            // climb the middle counter, then widen the plane for large offsets
            set_config({11'h000, bilr_pkg::ORDER_BSQ}, 13'd1, SIZE_W'(MAX_DIM), 13'd1);
            run_pixels(200);
            set_config({11'h000, bilr_pkg::ORDER_BSQ}, SIZE_W'(MAX_DIM), SIZE_W'(MAX_DIM),
                       SIZE_W'(MAX_DIM));
            run_pixels(20);
         end else begin
            // sometimes just pause with the settings left as they are
            if ($urandom_range(0, 3) != 0) begin
               set_config(CSR_DATA_W'($urandom_range(0, 8191)), pick_size(), pick_size(),
                          pick_size());
            end
            run_pixels($urandom_range(8, 60));
         end
         phase++;
      end

      calm = 1'b1;
      settle();
      repeat (8) @(posedge clock);
      if (slot_queue.size() != 0) begin
         report_error("results still outstanding at end of run");
      end
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
